/* rtl/ecp_pkg.sv */
// Shared types for the informed-sampling ellipse pipeline.
// Used by ecp_div_step and ellipse_covariance_from_path_core; depends on nothing.
package ecp_pkg;

	// One quotient bit per divider stage; in the short-path case the quotient fits in 64 bits.
	localparam int unsigned DivSteps = 64;

	typedef logic [64:0] divisor_t;

	// Partial remainder and the numerator bits not yet consumed, which the
	// quotient bits replace from the right as the word moves down the divider.
	typedef struct packed {
		logic [64:0] rem;
		logic [63:0] nq;
	} div_state_t;

	// Everything that rides alongside the divider lanes.
	typedef struct packed {
		logic signed [31:0] center_x;
		logic signed [31:0] center_y;
		logic [63:0]        vxx;
		logic [63:0]        vyy;
		logic [63:0]        vxy;
		divisor_t           c2;
		logic               shortp;
		logic               neg;
	} side_t;

endpackage

/* rtl/ecp_div_step.sv */
// One registered step of the restoring divider: produces one quotient bit.
// Depends on ecp_pkg.
module ecp_div_step (
	input  logic                 clk,
	input  logic                 en,
	input  ecp_pkg::divisor_t    d,
	input  ecp_pkg::div_state_t  st_in,
	output ecp_pkg::div_state_t  st_s
);

	logic [65:0] trial;
	logic [65:0] diff;
	logic        ge;

	always_comb begin
		trial = {st_in.rem, st_in.nq[63]};
		diff  = trial - {1'b0, d};
		ge    = trial >= {1'b0, d};
	end

	// While the seed remainder is below the divisor, the remainder stays below it, so 65 bits hold it.
	always_ff @(posedge clk) begin
		if (en) begin
			st_s.rem <= ge ? diff[64:0] : trial[64:0];
			st_s.nq  <= {st_in.nq[62:0], ge};
		end
	end

endmodule

/* rtl/ellipse_covariance_from_path_core.sv */
// Informed-sampling ellipse: midpoint and 2x2 covariance from start, goal and path length.
// Top level; depends on ecp_pkg and ecp_div_step.
//
// Usage: the input channel carries one word of start_x, start_y, goal_x, goal_y
// (signed fixed point with FRAC_BITS fraction bits) and path_length (unsigned,
// same format). A word is taken at a rising edge where in_valid is high and
// in_stall is low. The output channel returns one word per input word, in order:
// the midpoint, the covariance in Q32.32 and the too_short flag, taken where
// out_valid is high and out_stall is low.
// A word passes 71 register stages: six arithmetic stages, 64 divider stages
// that each retire one quotient bit, and the output register. The first stage
// loads at the accepting edge, and out_valid rises when the word reaches the output register.
// Throughput is one word per cycle while the receiver does not stall; the pipeline
// depth is set by the 64-bit quotient of the short-path case, which is always
// computed alongside the closed form and selected at the end.
// When the receiver stalls with a word waiting, the whole pipeline holds and
// in_stall rises in the same cycle; nothing is dropped or repeated.
// Reset clears every valid bit and out_valid; payload registers are not reset.
module ellipse_covariance_from_path_core #(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] start_x,
	input  logic signed [31:0] start_y,
	input  logic signed [31:0] goal_x,
	input  logic signed [31:0] goal_y,
	input  logic [31:0]        path_length,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] center_x,
	output logic signed [31:0] center_y,
	output logic [63:0]        cov_xx,
	output logic signed [63:0] cov_xy,
	output logic [63:0]        cov_yy,
	output logic               too_short
);

	localparam int NSteps = ecp_pkg::DivSteps;
	// Net scaling covers the divide by four and the move to 32 fraction bits.
	localparam int Shift = 30 - 2 * FRAC_BITS;
	localparam int unsigned LShift = (Shift > 0) ? Shift : 0;
	localparam int unsigned RShift = (Shift < 0) ? -Shift : 0;

	// The whole pipeline moves together unless a finished word is held back.
	logic en;
	assign en       = !(out_valid && out_stall);
	assign in_stall = out_valid && out_stall;

	// Stage 1: differences and coordinate sums.
	logic               v_s1;
	logic signed [32:0] dx_s1, dy_s1, sumx_s1, sumy_s1;
	logic [31:0]        len_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1   <= {goal_x[31], goal_x} - {start_x[31], start_x};
			dy_s1   <= {goal_y[31], goal_y} - {start_y[31], start_y};
			sumx_s1 <= {goal_x[31], goal_x} + {start_x[31], start_x};
			sumy_s1 <= {goal_y[31], goal_y} + {start_y[31], start_y};
			len_s1  <= path_length;
		end
	end

	// Stage 2: magnitudes, sign of the cross term, and the floored midpoint,
	// which is just an arithmetic shift of the 33-bit sum.
	logic               v_s2;
	logic [31:0]        ax_s2, ay_s2, len_s2;
	logic               neg_s2;
	logic signed [31:0] cx_s2, cy_s2;
	logic [32:0]        adx, ady;

	always_comb begin
		adx = dx_s1[32] ? 33'(-dx_s1) : 33'(dx_s1);
		ady = dy_s1[32] ? 33'(-dy_s1) : 33'(dy_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s2  <= adx[31:0];
			ay_s2  <= ady[31:0];
			len_s2 <= len_s1;
			neg_s2 <= dx_s1[32] ^ dy_s1[32];
			cx_s2  <= sumx_s1[32:1];
			cy_s2  <= sumy_s1[32:1];
		end
	end

	// Stage 3: the three 32x32 squares and the cross product.
	logic               v_s3;
	logic [63:0]        dx2_s3, dy2_s3, l2_s3, xy_s3;
	logic               neg_s3;
	logic signed [31:0] cx_s3, cy_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx2_s3 <= 64'(ax_s2) * 64'(ax_s2);
			dy2_s3 <= 64'(ay_s2) * 64'(ay_s2);
			l2_s3  <= 64'(len_s2) * 64'(len_s2);
			xy_s3  <= 64'(ax_s2) * 64'(ay_s2);
			neg_s3 <= neg_s2;
			cx_s3  <= cx_s2;
			cy_s3  <= cy_s2;
		end
	end

	// Stage 4: squared distance, short-path test, the closed-form terms, and
	// the 32x32 partial products of L^2 times each numerator factor.
	logic               v_s4;
	logic [64:0]        c2_s4;
	logic               short_s4, neg_s4;
	logic [63:0]        nxx_s4, nyy_s4, nxy_s4;
	logic signed [31:0] cx_s4, cy_s4;
	logic [63:0]        pp_s4 [3][4];
	logic [63:0]        fac [3];
	logic [64:0]        c2_next;

	always_comb begin
		fac[0]  = dx2_s3;
		fac[1]  = dy2_s3;
		fac[2]  = xy_s3;
		c2_next = {1'b0, dx2_s3} + {1'b0, dy2_s3};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c2_s4    <= c2_next;
			short_s4 <= {1'b0, l2_s3} < c2_next;
			nxx_s4   <= l2_s3 - dy2_s3;
			nyy_s4   <= l2_s3 - dx2_s3;
			nxy_s4   <= xy_s3;
			neg_s4   <= neg_s3;
			cx_s4    <= cx_s3;
			cy_s4    <= cy_s3;
			for (int k = 0; k < 3; k++) begin
				pp_s4[k][0] <= 64'(l2_s3[31:0])  * 64'(fac[k][31:0]);
				pp_s4[k][1] <= 64'(l2_s3[31:0])  * 64'(fac[k][63:32]);
				pp_s4[k][2] <= 64'(l2_s3[63:32]) * 64'(fac[k][31:0]);
				pp_s4[k][3] <= 64'(l2_s3[63:32]) * 64'(fac[k][63:32]);
			end
		end
	end

	// Stage 5: middle partial products summed.
	logic          v_s5;
	logic [64:0]   mid_s5 [3];
	logic [63:0]   lo_s5 [3], hi_s5 [3];
	ecp_pkg::side_t side_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				mid_s5[k] <= {1'b0, pp_s4[k][1]} + {1'b0, pp_s4[k][2]};
				lo_s5[k]  <= pp_s4[k][0];
				hi_s5[k]  <= pp_s4[k][3];
			end
			side_s5.center_x <= cx_s4;
			side_s5.center_y <= cy_s4;
			side_s5.vxx      <= nxx_s4;
			side_s5.vyy      <= nyy_s4;
			side_s5.vxy      <= nxy_s4;
			side_s5.c2       <= c2_s4;
			side_s5.shortp   <= short_s4;
			side_s5.neg      <= neg_s4;
		end
	end

	// Stage 6: full 128-bit numerators.
	logic           v_s6;
	logic [127:0]   num_s6 [3];
	ecp_pkg::side_t side_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				num_s6[k] <= {64'd0, lo_s5[k]} + ({63'd0, mid_s5[k]} << 32)
					+ {hi_s5[k], 64'd0};
			end
			side_s6 <= side_s5;
		end
	end

	// Divider stages. The quotient is below 2^64 in the short-path case, so
	// the upper numerator half already sits below the divisor and seeds the
	// remainder directly. In the other case the lanes run on harmless data.
	ecp_pkg::div_state_t st [3][NSteps+1];
	ecp_pkg::side_t      div_side_s [NSteps+1];
	logic                div_v_s [NSteps+1];

	for (genvar k = 0; k < 3; k++) begin : g_lane
		assign st[k][0].rem = {1'b0, num_s6[k][127:64]};
		assign st[k][0].nq  = num_s6[k][63:0];
		for (genvar i = 0; i < NSteps; i++) begin : g_step
			ecp_div_step u_step (
				.clk   (clk),
				.en    (en),
				.d     (div_side_s[i].c2),
				.st_in (st[k][i]),
				.st_s  (st[k][i+1])
			);
		end
	end

	assign div_side_s[0] = side_s6;
	assign div_v_s[0]    = v_s6;

	for (genvar i = 0; i < NSteps; i++) begin : g_side
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_v_s[i+1] <= 1'b0;
			end else if (en) begin
				div_v_s[i+1] <= div_v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				div_side_s[i+1] <= div_side_s[i];
			end
		end
	end

	// Output stage: pick the short-path quotients or the closed form, then
	// scale to Q32.32 with saturation, and restore the sign of the cross term.
	function automatic logic [63:0] rescale(input logic [63:0] v);
		logic [63:0] r;
		if (LShift > 0 && (v >> (64 - LShift)) != 64'd0) begin
			r = '1;
		end else begin
			r = (v << LShift) >> RShift;
		end
		return r;
	endfunction

	ecp_pkg::side_t fin;
	logic [63:0]    sxx, syy, sxy, sxy_signed;

	always_comb begin
		fin = div_side_s[NSteps];
		sxx = rescale(fin.shortp ? st[0][NSteps].nq : fin.vxx);
		syy = rescale(fin.shortp ? st[1][NSteps].nq : fin.vyy);
		sxy = rescale(fin.shortp ? st[2][NSteps].nq : fin.vxy);
		if (!fin.neg) begin
			sxy_signed = sxy[63] ? {1'b0, {63{1'b1}}} : sxy;
		end else if (sxy[63]) begin
			sxy_signed = {1'b1, 63'd0};
		end else begin
			sxy_signed = -sxy;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= div_v_s[NSteps];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			center_x  <= fin.center_x;
			center_y  <= fin.center_y;
			cov_xx    <= sxx;
			cov_yy    <= syy;
			cov_xy    <= sxy_signed;
			too_short <= fin.shortp;
		end
	end

endmodule

/* tb/ellipse_covariance_from_path_core_test.sv */
// Testbench for ellipse_covariance_from_path_core: drives start/goal/length words
// and checks midpoint, covariance and too_short against an in-bench predictor.
// Depends only on the RTL top level (and ecp_pkg through it).
module ellipse_covariance_from_path_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FracBits = 16;
	localparam int Latency = 71;
	localparam int IdleLimit = 20000;

	// One input word and one result word, at the block's widths.
	typedef struct packed {
		logic signed [31:0] sx;
		logic signed [31:0] sy;
		logic signed [31:0] gx;
		logic signed [31:0] gy;
		logic [31:0]        len;
	} path_word_t;

	typedef struct packed {
		logic signed [31:0] cx;
		logic signed [31:0] cy;
		logic [63:0]        xx;
		logic signed [63:0] xy;
		logic [63:0]        yy;
		logic               shortp;
	} ellipse_word_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic signed [31:0] start_x;
	logic signed [31:0] start_y;
	logic signed [31:0] goal_x;
	logic signed [31:0] goal_y;
	logic [31:0]        path_length;
	logic               out_valid;
	logic               out_stall;
	logic signed [31:0] center_x;
	logic signed [31:0] center_y;
	logic [63:0]        cov_xx;
	logic signed [63:0] cov_xy;
	logic [63:0]        cov_yy;
	logic               too_short;

	ellipse_covariance_from_path_core #(.FRAC_BITS(FracBits)) i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.start_x(start_x), .start_y(start_y), .goal_x(goal_x), .goal_y(goal_y),
		.path_length(path_length),
		.out_valid(out_valid), .out_stall(out_stall),
		.center_x(center_x), .center_y(center_y),
		.cov_xx(cov_xx), .cov_xy(cov_xy), .cov_yy(cov_yy), .too_short(too_short)
	);

	// Expected ellipses, oldest first.
	ellipse_word_t pending_ellipses[$];
	int unsigned   mismatch_count = 0;
	int unsigned   quiet_cycles = 0;
	int unsigned   send_idle_pct = 0;
	int unsigned   recv_idle_pct = 0;
	bit            hold_receiver = 0;

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// Multiply by 2^(30-2*FracBits). With 16 fraction bits this is a right shift
	// by two, which truncates; the left-shift branch saturates on overflow.
	function automatic logic [63:0] to_q32(input logic [63:0] v);
		int s;
		s = 30 - 2 * FracBits;
		if (s > 0) begin
			if ((v >> (64 - s)) != 0)
				return '1;
			return v << s;
		end
		return v >> (-s);
	endfunction

	// The ellipse for one path word. The covariance uses the angle-free closed
	// form; when the path is shorter than the distance the minor axis is zero
	// and each term becomes L^2 * (product of components) / c^2.
	function automatic ellipse_word_t ellipse_of(input path_word_t w);
		ellipse_word_t       e;
		logic signed [33:0]  dx, dy, sum_x, sum_y;
		logic [32:0]         ax, ay;
		logic [63:0]         dx2, dy2, l2, axy, vxx, vyy, vxy, mag;
		logic [64:0]         c2;
		logic [127:0]        num;
		logic                neg;
		dx = 34'(w.gx) - 34'(w.sx);
		dy = 34'(w.gy) - 34'(w.sy);
		ax = dx < 0 ? 33'(-dx) : 33'(dx);
		ay = dy < 0 ? 33'(-dy) : 33'(dy);
		dx2 = 64'(ax) * 64'(ax);
		dy2 = 64'(ay) * 64'(ay);
		axy = 64'(ax) * 64'(ay);
		l2 = 64'(w.len) * 64'(w.len);
		c2 = 65'(dx2) + 65'(dy2);
		e.shortp = c2 > 65'(l2);
		neg = (dx < 0) != (dy < 0);
		if (!e.shortp) begin
			vxx = l2 - dy2;
			vyy = l2 - dx2;
			vxy = axy;
		end else begin
			num = 128'(l2) * 128'(dx2);
			vxx = 64'(num / 128'(c2));
			num = 128'(l2) * 128'(dy2);
			vyy = 64'(num / 128'(c2));
			num = 128'(l2) * 128'(axy);
			vxy = 64'(num / 128'(c2));
		end
		// Midpoint rounds toward minus infinity, which the arithmetic shift gives.
		sum_x = 34'(w.sx) + 34'(w.gx);
		sum_y = 34'(w.sy) + 34'(w.gy);
		e.cx = 32'(sum_x >>> 1);
		e.cy = 32'(sum_y >>> 1);
		e.xx = to_q32(vxx);
		e.yy = to_q32(vyy);
		mag = to_q32(vxy);
		if (!neg)
			e.xy = mag[63] ? 64'h7fff_ffff_ffff_ffff : mag;
		else
			e.xy = mag[63] ? 64'h8000_0000_0000_0000 : -mag;
		return e;
	endfunction

	// Offers one word, with a random gap before it, and waits until it is taken.
	// Valid stays high afterwards so the next word can follow with no gap.
	task automatic send_word(input path_word_t w);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		{start_x, start_y, goal_x, goal_y, path_length} <= w;
		pending_ellipses.push_back(ellipse_of(w));
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(3))
			0: return $urandom;
			1: return 32'($signed($urandom_range(2000000)) - 1000000);
			2: return 32'($signed($urandom_range(4000)) - 2000) << FracBits;
			default: return $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
		endcase
	endfunction

	function automatic path_word_t rand_word();
		path_word_t     w;
		w.sx = rand_coord();
		w.sy = rand_coord();
		// Goals near the start keep most paths long enough to be well formed.
		if ($urandom_range(1)) begin
			w.gx = w.sx + 32'($signed($urandom_range(200000)) - 100000);
			w.gy = w.sy + 32'($signed($urandom_range(200000)) - 100000);
		end else begin
			w.gx = rand_coord();
			w.gy = rand_coord();
		end
		w.len = $urandom;
		if ($urandom_range(3) == 0)
			w.len = $urandom_range(300000);
		return w;
	endfunction

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_ellipses.size() != 0)
			@(negedge clk);
		repeat (Latency + 5) @(negedge clk);
	endtask

	// Extremes of every field, start equal to goal, exact and short paths.
	task automatic test_directed();
		path_word_t w;
		send_word('0);
		send_word({32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'hffff_ffff});
		send_word({32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'hffff_ffff});
		send_word({32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h0});
		send_word({32'h8000_0000, 32'h0, 32'h7fff_ffff, 32'h0, 32'hffff_ffff});
		send_word({32'hffff_ffff, 32'hffff_ffff, 32'h0, 32'h0, 32'h1});
		// Equal points: covariance is diag(L^2/4, L^2/4).
		send_word({32'h0001_0000, 32'hfffe_0000, 32'h0001_0000, 32'hfffe_0000, 32'h0004_0000});
		// 3-4-5 triangle, exactly as long as the distance, then one ulp short.
		w = {32'h0, 32'h0, 32'h0003_0000, 32'h0004_0000, 32'h0005_0000};
		send_word(w);
		w.len = 32'h0004_ffff;
		send_word(w);
		// Opposite signs of dx and dy give a negative cross term.
		send_word({32'h0, 32'h0, 32'hfffd_0000, 32'h0004_0000, 32'h000a_0000});
		send_word({32'h0, 32'h0, 32'h0003_0000, 32'hfffc_0000, 32'h0002_0000});
		// Vertical and horizontal segments, where dx or dy is zero.
		send_word({32'h0, 32'h0, 32'h0, 32'h0007_0000, 32'h0001_0000});
		send_word({32'h0, 32'h0, 32'hfff9_0000, 32'h0, 32'h0010_0000});
		send_word({32'h5555_5555, 32'haaaa_aaaa, 32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa});
	endtask

	task automatic test_random(input int unsigned n);
		repeat (n) send_word(rand_word());
	endtask

	// The receiver holds off for a long stretch while words keep coming, so the
	// pipeline fills and in_stall has to rise.
	task automatic test_backpressure();
		hold_receiver = 1;
		fork
			test_random(120);
			begin
				repeat (300) @(negedge clk);
				hold_receiver = 0;
			end
		join
	endtask

	// Receiver stall, changed at the falling edge like every other input.
	always @(negedge clk)
		out_stall <= hold_receiver || ($urandom_range(99) < recv_idle_pct);

	// Result checker: sampled at the rising edge where a word is taken.
	always @(posedge clk) begin
		ellipse_word_t got, want;
		if (arst_n && out_valid && !out_stall) begin
			got = {center_x, center_y, cov_xx, cov_xy, cov_yy, too_short};
			if (pending_ellipses.size() == 0) begin
				$display("%t: unexpected result word %h", $realtime, got);
				mismatch_count++;
			end else begin
				want = pending_ellipses.pop_front();
				if (got.cx !== want.cx)
					$display("%t: center_x expected %h actual %h", $realtime, want.cx, got.cx);
				if (got.cy !== want.cy)
					$display("%t: center_y expected %h actual %h", $realtime, want.cy, got.cy);
				if (got.xx !== want.xx)
					$display("%t: cov_xx expected %h actual %h", $realtime, want.xx, got.xx);
				if (got.xy !== want.xy)
					$display("%t: cov_xy expected %h actual %h", $realtime, want.xy, got.xy);
				if (got.yy !== want.yy)
					$display("%t: cov_yy expected %h actual %h", $realtime, want.yy, got.yy);
				if (got.shortp !== want.shortp)
					$display("%t: too_short expected %b actual %b", $realtime,
						want.shortp, got.shortp);
				if (got !== want)
					mismatch_count++;
			end
		end
	end

	// Watchdog: counts cycles in which neither channel takes a word.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= IdleLimit) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		out_stall = 1'b0;
		{start_x, start_y, goal_x, goal_y, path_length} = '0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_idle_pct = 33;
		recv_idle_pct = 47;
		test_directed();
		test_random(150);
		send_idle_pct = 47;
		recv_idle_pct = 33;
		test_random(150);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_backpressure();
		test_random(30);
		wait_drained();

		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule
